@@ sv/stb_pkg.sv @@
`timescale 1ns / 1ps
// stb_pkg: constants and types shared by the timer bank
// no dependencies

package stb_pkg;

    // number of timers in the bank (1 to 255)
    localparam int TIMER_COUNT = 8;
    localparam int TIMER_IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

    // field widths
    localparam int CMD_W    = 2;
    localparam int ID_W     = 8;
    localparam int PERIOD_W = 32;
    localparam int MASK_W   = 8;
    localparam int RUN_W    = 31;
    localparam int DIV_W    = 8;

    // fired mask shows at most MASK_W timers
    localparam int MASK_PAD_W = (TIMER_COUNT > MASK_W) ? TIMER_COUNT : MASK_W;

    // run-time counter wraps to zero when it would reach this value
    localparam logic [RUN_W-1:0] RUN_WRAP = {RUN_W{1'b1}};

    // divider reset values
    localparam logic [DIV_W-1:0] FAST_RESET = 8'd10;
    localparam logic [DIV_W-1:0] SLOW_RESET = 8'd50;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FAST_DIVIDE = 1'b0,
        CFG_SLOW_DIVIDE = 1'b1
    } t_cfg_idx;

    // request commands
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK       = 2'd0,
        CMD_START_ONE  = 2'd1,
        CMD_START_AUTO = 2'd2,
        CMD_STOP       = 2'd3
    } t_cmd;

endpackage

@@ sv/soft_timer_bank.sv @@
`timescale 1ns / 1ps
// soft_timer_bank: bank of down-counting timers with one-shot and auto-reload modes
// depends on stb_pkg
//
// Usage
//   Requests enter on the input channel (i_in_valid / o_in_ready) and carry a
//   command, a timer id and a period. A tick decrements every nonzero count,
//   reloads expired auto-mode timers and reports armed expiries in
//   o_fired_mask; it also advances the run-time counter and the two divided
//   tick pulses. Start commands load and arm a timer, stop disarms it only.
//   Every request gives exactly one result on the output channel
//   (o_out_valid / i_out_ready); out-of-range start or stop ids set o_bad_id.
//   A request passes from the input register to the update stage, which
//   writes the result register. Throughput is one request per cycle while
//   the receiver takes results, set by the single update stage in which all
//   timers change together.
//   When the receiver stalls, the result register holds and the input
//   register takes at most one further request before o_in_ready drops.
//   The divide registers are to be written through i_cfg_we / i_cfg_index /
//   i_cfg_data only while no request is in flight; the block does not check.
//   Reset (synchronous, active low) clears all timers, the run-time counter
//   and the divider counts, and restores the divide values to 10 and 50.

module soft_timer_bank
    import stb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic [ID_W-1:0]      i_timer_id,
    input  logic [PERIOD_W-1:0]  i_period,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [MASK_W-1:0]    o_fired_mask,
    output logic                 o_pulse_fast,
    output logic                 o_pulse_slow,
    output logic [RUN_W-1:0]     o_run_time,
    output logic                 o_bad_id,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIV_W-1:0]     i_cfg_data
);

    // input register
    logic                 r_in_valid;
    t_cmd                 r_cmd;
    logic [ID_W-1:0]      r_id;
    logic [PERIOD_W-1:0]  r_period;

    // timer state
    logic [PERIOD_W-1:0]  r_remaining [TIMER_COUNT];
    logic [PERIOD_W-1:0]  r_reload    [TIMER_COUNT];
    logic [TIMER_COUNT-1:0] r_auto;
    logic [TIMER_COUNT-1:0] r_armed;
    logic [RUN_W-1:0]     r_elapsed;
    logic [DIV_W-1:0]     r_fast_count;
    logic [DIV_W-1:0]     r_slow_count;
    logic [DIV_W-1:0]     r_fast_divide;
    logic [DIV_W-1:0]     r_slow_divide;

    // result register
    logic                 r_out_valid;
    logic [MASK_W-1:0]    r_fired;
    logic                 r_pulse_fast;
    logic                 r_pulse_slow;
    logic                 r_bad_id;

    // next values
    logic [PERIOD_W-1:0]  n_remaining [TIMER_COUNT];
    logic [PERIOD_W-1:0]  n_reload    [TIMER_COUNT];
    logic [TIMER_COUNT-1:0] n_auto;
    logic [TIMER_COUNT-1:0] n_armed;
    logic [RUN_W-1:0]     n_elapsed;
    logic [DIV_W-1:0]     n_fast_count;
    logic [DIV_W-1:0]     n_slow_count;
    logic [MASK_W-1:0]    n_fired;
    logic                 n_pulse_fast;
    logic                 n_pulse_slow;
    logic                 n_bad_id;

    logic                 advance;
    logic                 id_ok;
    logic [TIMER_IDX_W-1:0] idx;
    logic [TIMER_COUNT-1:0] fire_vec;
    logic [MASK_PAD_W-1:0]  fire_pad;
    logic [PERIOD_W-1:0]  dec [TIMER_COUNT];
    logic [RUN_W-1:0]     run_inc;
    logic [DIV_W-1:0]     fast_inc;
    logic [DIV_W-1:0]     slow_inc;

    // handshake
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    assign id_ok = (r_id < ID_W'(TIMER_COUNT));
    assign idx   = r_id[TIMER_IDX_W-1:0];

    // tick arithmetic for the shared counters
    assign run_inc  = r_elapsed + RUN_W'(1);
    assign fast_inc = r_fast_count + DIV_W'(1);
    assign slow_inc = r_slow_count + DIV_W'(1);

    // update stage: one request changes the whole bank
    always_comb begin
        n_remaining  = r_remaining;
        n_reload     = r_reload;
        n_auto       = r_auto;
        n_armed      = r_armed;
        n_elapsed    = r_elapsed;
        n_fast_count = r_fast_count;
        n_slow_count = r_slow_count;
        n_pulse_fast = 1'b0;
        n_pulse_slow = 1'b0;
        n_bad_id     = 1'b0;
        fire_vec     = '0;

        for (int i = 0; i < TIMER_COUNT; i++) begin
            dec[i] = r_remaining[i] - PERIOD_W'(1);
        end

        case (r_cmd)
            CMD_TICK: begin
                // every running count steps down, expiries reload or disarm
                for (int i = 0; i < TIMER_COUNT; i++) begin
                    if (r_remaining[i] != '0) begin
                        n_remaining[i] = dec[i];
                        if (dec[i] == '0) begin
                            if (r_auto[i]) begin
                                n_remaining[i] = r_reload[i];
                            end
                            if (r_armed[i]) begin
                                fire_vec[i] = 1'b1;
                                if (!r_auto[i]) begin
                                    n_armed[i] = 1'b0;
                                end
                            end
                        end
                    end
                end
                // run-time counter skips the wrap value
                n_elapsed = (run_inc == RUN_WRAP) ? '0 : run_inc;
                // divided ticks
                if (fast_inc >= r_fast_divide) begin
                    n_fast_count = '0;
                    n_pulse_fast = 1'b1;
                end else begin
                    n_fast_count = fast_inc;
                end
                if (slow_inc >= r_slow_divide) begin
                    n_slow_count = '0;
                    n_pulse_slow = 1'b1;
                end else begin
                    n_slow_count = slow_inc;
                end
            end
            CMD_STOP: begin
                if (!id_ok) begin
                    n_bad_id = 1'b1;
                end else begin
                    n_armed[idx] = 1'b0;
                end
            end
            CMD_START_ONE, CMD_START_AUTO: begin
                if (!id_ok) begin
                    n_bad_id = 1'b1;
                end else begin
                    n_remaining[idx] = r_period;
                    n_reload[idx]    = r_period;
                    n_auto[idx]      = (r_cmd == CMD_START_AUTO);
                    n_armed[idx]     = 1'b1;
                end
            end
            default: begin
                n_bad_id = 1'b0;
            end
        endcase

        // only the low timers show in the mask
        fire_pad = MASK_PAD_W'(fire_vec);
        n_fired  = fire_pad[MASK_W-1:0];
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_cmd    <= t_cmd'(i_cmd);
            r_id     <= i_timer_id;
            r_period <= i_period;
        end
    end

    // divide registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_divide <= FAST_RESET;
            r_slow_divide <= SLOW_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FAST_DIVIDE: r_fast_divide <= i_cfg_data;
                CFG_SLOW_DIVIDE: r_slow_divide <= i_cfg_data;
                default: r_fast_divide <= r_fast_divide;
            endcase
        end
    end

    // timer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TIMER_COUNT; i++) begin
                r_remaining[i] <= '0;
                r_reload[i]    <= '0;
            end
            r_auto       <= '0;
            r_armed      <= '0;
            r_elapsed    <= '0;
            r_fast_count <= '0;
            r_slow_count <= '0;
        end else if (advance) begin
            r_remaining  <= n_remaining;
            r_reload     <= n_reload;
            r_auto       <= n_auto;
            r_armed      <= n_armed;
            r_elapsed    <= n_elapsed;
            r_fast_count <= n_fast_count;
            r_slow_count <= n_slow_count;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_fired      <= n_fired;
            r_pulse_fast <= n_pulse_fast;
            r_pulse_slow <= n_pulse_slow;
            r_bad_id     <= n_bad_id;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_fired_mask = r_fired;
    assign o_pulse_fast = r_pulse_fast;
    assign o_pulse_slow = r_pulse_slow;
    assign o_run_time   = r_elapsed;
    assign o_bad_id     = r_bad_id;

endmodule

@@ sim/timer_bank_checker.sv @@
`timescale 1ns / 1ps
// timer_bank_checker: watches the request, result and divide-write ports of soft_timer_bank
// keeps its own copy of the timer bank, predicts each result and compares field by field
// depends on stb_pkg

module timer_bank_checker
    import stb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic [ID_W-1:0]      i_timer_id,
    input  logic [PERIOD_W-1:0]  i_period,
    // result channel
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [MASK_W-1:0]    i_fired_mask,
    input  logic                 i_pulse_fast,
    input  logic                 i_pulse_slow,
    input  logic [RUN_W-1:0]     i_run_time,
    input  logic                 i_bad_id,
    // divide register writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIV_W-1:0]     i_cfg_data,
    // towards the testbench top
    output int                   o_pending,
    output int                   o_mismatches
);

    typedef struct packed {
        logic [MASK_W-1:0] fired_mask;
        logic              pulse_fast;
        logic              pulse_slow;
        logic [RUN_W-1:0]  run_time;
        logic              bad_id;
    } t_bank_result;

    // shadow copy of the timer bank
    logic [PERIOD_W-1:0] count_left [TIMER_COUNT];
    logic [PERIOD_W-1:0] reload     [TIMER_COUNT];
    logic                auto_mode  [TIMER_COUNT];
    logic                armed      [TIMER_COUNT];
    logic [RUN_W-1:0]    ticks_seen;
    logic [DIV_W-1:0]    fast_cnt;
    logic [DIV_W-1:0]    slow_cnt;
    logic [DIV_W-1:0]    fast_div;
    logic [DIV_W-1:0]    slow_div;

    t_bank_result results_due[$];
    int           mismatch_total = 0;

    assign o_mismatches = mismatch_total;

    // divided tick count after one tick; it lands on zero exactly when the pulse fires
    function automatic logic [DIV_W-1:0] next_div_count(input logic [DIV_W-1:0] cnt,
                                                        input logic [DIV_W-1:0] div);
        logic [DIV_W-1:0] nxt;
        nxt = cnt + 1'b1;
        return (nxt >= div) ? '0 : nxt;
    endfunction

    // apply one request to the shadow bank and return the result it gives
    function automatic t_bank_result apply_request(input t_cmd               cmd,
                                                   input logic [ID_W-1:0]     id,
                                                   input logic [PERIOD_W-1:0] period);
        t_bank_result     res;
        logic [RUN_W-1:0] run_next;
        res = '0;
        if (cmd == CMD_TICK) begin
            for (int t = 0; t < TIMER_COUNT; t++) begin
                if (count_left[t] != '0) begin
                    count_left[t] = count_left[t] - 1'b1;
                    if (count_left[t] == '0) begin
                        // expiry reloads in auto mode whether armed or not
                        if (auto_mode[t])
                            count_left[t] = reload[t];
                        if (armed[t]) begin
                            if (t < MASK_W)
                                res.fired_mask[t] = 1'b1;
                            if (!auto_mode[t])
                                armed[t] = 1'b0;
                        end
                    end
                end
            end
            run_next   = ticks_seen + 1'b1;
            ticks_seen = (run_next == RUN_WRAP) ? '0 : run_next;
            fast_cnt   = next_div_count(fast_cnt, fast_div);
            slow_cnt   = next_div_count(slow_cnt, slow_div);
            res.pulse_fast = (fast_cnt == '0);
            res.pulse_slow = (slow_cnt == '0);
        end else if (id >= TIMER_COUNT) begin
            res.bad_id = 1'b1;
        end else if (cmd == CMD_STOP) begin
            armed[id] = 1'b0;
        end else begin
            count_left[id] = period;
            reload[id]     = period;
            auto_mode[id]  = (cmd == CMD_START_AUTO);
            armed[id]      = 1'b1;
        end
        res.run_time = ticks_seen;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_total++;
        end
    endfunction

    // track writes, compare results, predict on each accepted request
    always @(posedge i_clk) begin
        t_bank_result want;
        if (!i_rst_n) begin
            for (int t = 0; t < TIMER_COUNT; t++) begin
                count_left[t] = '0;
                reload[t]     = '0;
                auto_mode[t]  = 1'b0;
                armed[t]      = 1'b0;
            end
            ticks_seen = '0;
            fast_cnt   = '0;
            slow_cnt   = '0;
            fast_div   = FAST_RESET;
            slow_div   = SLOW_RESET;
            results_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FAST_DIVIDE: fast_div = i_cfg_data;
                    CFG_SLOW_DIVIDE: slow_div = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    mismatch_total++;
                end else begin
                    want = results_due.pop_front();
                    check_field("fired_mask", want.fired_mask, i_fired_mask);
                    check_field("pulse_fast", want.pulse_fast, i_pulse_fast);
                    check_field("pulse_slow", want.pulse_slow, i_pulse_slow);
                    check_field("run_time",   want.run_time,   i_run_time);
                    check_field("bad_id",     want.bad_id,     i_bad_id);
                end
            end
            if (i_in_valid && i_in_ready)
                results_due.push_back(apply_request(t_cmd'(i_cmd), i_timer_id, i_period));
        end
        o_pending <= results_due.size();
    end

endmodule

@@ sim/tb_soft_timer_bank.sv @@
`timescale 1ns / 1ps
// tb_soft_timer_bank: drives requests and divide writes into soft_timer_bank, stalls the
// result side at random and gives the verdict; checking lives in timer_bank_checker
// depends on stb_pkg, soft_timer_bank and timer_bank_checker

module tb_soft_timer_bank;
    import stb_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 255;
    localparam int PHASES       = 6;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic [CMD_W-1:0]     i_cmd       = '0;
    logic [ID_W-1:0]      i_timer_id  = '0;
    logic [PERIOD_W-1:0]  i_period    = '0;
    logic                 i_out_ready = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DIV_W-1:0]     i_cfg_data  = '0;

    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [MASK_W-1:0]    o_fired_mask;
    logic                 o_pulse_fast;
    logic                 o_pulse_slow;
    logic [RUN_W-1:0]     o_run_time;
    logic                 o_bad_id;

    int pending;
    int mismatches;
    int quiet_cycles  = 0;
    bit gaps_on       = 1'b0;
    int hold_requests = 0;
    int request_total = 0;
    int tick_total    = 0;
    int bad_total     = 0;

    soft_timer_bank dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_timer_id   (i_timer_id),
        .i_period     (i_period),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_fired_mask (o_fired_mask),
        .o_pulse_fast (o_pulse_fast),
        .o_pulse_slow (o_pulse_slow),
        .o_run_time   (o_run_time),
        .o_bad_id     (o_bad_id),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    timer_bank_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_timer_id   (i_timer_id),
        .i_period     (i_period),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_fired_mask (o_fired_mask),
        .i_pulse_fast (o_pulse_fast),
        .i_pulse_slow (o_pulse_slow),
        .i_run_time   (o_run_time),
        .i_bad_id     (o_bad_id),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // mostly no gap, some short ones, a few long
    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // offer one request and hold it until accepted
    task automatic send_request(input t_cmd cmd, input logic [ID_W-1:0] id,
                                input logic [PERIOD_W-1:0] period);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_timer_id <= id;
        i_period   <= period;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        request_total++;
        if (cmd == CMD_TICK)
            tick_total++;
        else if (id >= TIMER_COUNT)
            bad_total++;
    endtask

    // drop valid and wait until every result is back and the pipeline is empty
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [DIV_W-1:0] value);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // ticks about half the time, starts mostly with short periods so timers expire often
    task automatic send_random();
        int                  pick;
        int                  sel;
        logic [ID_W-1:0]     id;
        logic [PERIOD_W-1:0] period;
        pick = $urandom_range(0, 99);
        sel  = $urandom_range(0, 99);
        id   = ID_W'($urandom_range(0, TIMER_COUNT - 1));
        if (sel < 70)
            period = $urandom_range(1, 12);
        else if (sel < 82)
            period = $urandom_range(13, 60);
        else if (sel < 92)
            period = '0;
        else
            period = $urandom;
        if (pick < 50)
            send_request(CMD_TICK, ID_W'($urandom), $urandom);
        else if (pick < 72)
            send_request(CMD_START_ONE, id, period);
        else if (pick < 88)
            send_request(CMD_START_AUTO, id, period);
        else if (pick < 96)
            send_request(CMD_STOP, id, period);
        else
            send_request(t_cmd'($urandom_range(1, 3)),
                         ID_W'($urandom_range(TIMER_COUNT, 255)), period);
    endtask

    // result side: random stalls plus one long hold-off when asked
    initial begin
        int hold;
        int holds_done;
        hold       = 0;
        holds_done = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
                i_out_ready <= 1'b0;
            end else if (holds_done < hold_requests) begin
                holds_done++;
                hold = LONG_HOLD - 1;
                i_out_ready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 99) < 15) begin
                hold = pick_gap();
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no request or result moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: nothing moved for %0d cycles", IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus and verdict
    initial begin
        logic [DIV_W-1:0] fast_table [PHASES-1];
        logic [DIV_W-1:0] slow_table [PHASES-1];
        fast_table = '{8'd1, 8'd255, 8'd0, 8'd3, 8'd255};
        slow_table = '{8'd255, 8'd1, 8'd2, 8'd0, 8'd7};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset divides, every command, zero and full periods, bad ids
        send_request(CMD_TICK, '0, '0);
        send_request(CMD_START_ONE, 8'd0, 32'd2);
        send_request(CMD_START_AUTO, 8'd7, 32'd3);
        send_request(CMD_START_ONE, 8'd3, 32'd0);
        send_request(CMD_START_AUTO, 8'd5, 32'hFFFF_FFFF);
        // one-shot stopped before expiry
        send_request(CMD_START_ONE, 8'd1, 32'd1);
        send_request(CMD_STOP, 8'd1, '0);
        // auto timer stopped keeps reloading silently
        send_request(CMD_START_AUTO, 8'd2, 32'd2);
        send_request(CMD_STOP, 8'd2, '0);
        send_request(CMD_START_ONE, 8'd8, 32'd5);
        send_request(CMD_START_AUTO, 8'hFF, 32'hFFFF_FFFF);
        send_request(CMD_STOP, 8'h80, 32'h0);
        repeat (7) send_request(CMD_TICK, 8'hFF, 32'hFFFF_FFFF);
        send_request(CMD_STOP, 8'd7, '0);
        repeat (3) send_request(CMD_TICK, '0, '0);

        // random phases, each under its own divide setting
        for (int p = 0; p < PHASES; p++) begin
            if (p < PHASES - 1) begin
                write_register(CFG_FAST_DIVIDE, fast_table[p]);
                write_register(CFG_SLOW_DIVIDE, slow_table[p]);
            end else begin
                write_register(CFG_FAST_DIVIDE, DIV_W'($urandom_range(1, 255)));
                write_register(CFG_SLOW_DIVIDE, DIV_W'($urandom_range(1, 255)));
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                gaps_on = ((k / 64) % 3) != 2;
                if (p == 1 && k == 100)
                    hold_requests++;
                send_random();
            end
        end

        settle();
        $display("covered %0d requests: %0d ticks, %0d out-of-range ids, %0d divide settings",
                 request_total, tick_total, bad_total, PHASES + 1);
        $display("random stalls on both sides and one %0d-cycle result hold-off", LONG_HOLD);
        if (mismatches == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
